// ===== rtl/core/tfvc_pkg.sv =====
// Package for the target follow velocity controller.
// Holds datapath widths, CORDIC constants and register indexes.
// No dependencies.
`default_nettype none

package tfvc_pkg;

	// CORDIC x/y width: the input is 32 bits, and it grows through pre-rotation and CORDIC gain.
	localparam int XW = 36;
	// Angle accumulator width, signed Q2.30 with headroom.
	localparam int ZW = 34;
	// Distance width, unsigned integer of the input scale.
	localparam int DW = 35;
	// Number of arctangent table entries.
	localparam int ATAN_ENTRIES = 24;

	// pi/2 in Q2.30.
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	// Reciprocal of the limit CORDIC gain in Q2.30.
	localparam logic [29:0] KINV_Q30 = 30'd652032874;

	// Configuration register indexes.
	localparam logic [2:0] REG_LINEAR_GAIN  = 3'd0;
	localparam logic [2:0] REG_ANGULAR_GAIN = 3'd1;
	localparam logic [2:0] REG_MAX_LINEAR   = 3'd2;
	localparam logic [2:0] REG_MAX_ANGULAR  = 3'd3;
	localparam logic [2:0] REG_STOP_DIST    = 3'd4;
	localparam logic [2:0] REG_HEAD_OFFSET  = 3'd5;

	// Arctangent of 2^-i in Q2.30, truncated.
	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/target_follow_velocity_controller_top.sv =====
// Top level of the target follow velocity controller.
// Depends on tfvc_pkg for widths, CORDIC constants and register indexes.
`default_nettype none

// Turns a target position (x ahead, y to the left, signed fixed point) into a
// forward and a turn speed. A vectoring CORDIC gives distance and bearing, the
// heading offset is subtracted, and proportional gains with caps and deadbands
// give the two speeds. The pipeline takes one word per clock; a word passes
// through one input register, one register per CORDIC iteration and four
// stages of multiply, sum and clamp. The whole pipeline holds while the
// output word is not taken.
// Configuration writes are meant to happen only while the pipeline is empty.
module target_follow_velocity_controller_top
	import tfvc_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [30:0] cfg_data,
	// Input words: target_x [31:0], target_y [63:32].
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,
	// Output words: forward_speed [30:0], turn_speed [62:31], zero [63].
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata
);

	// Rounded angle width, and angle width after the offset subtraction.
	localparam int ARW = FRAC_BITS + 5;
	localparam int AW  = ((ARW > 19) ? ARW : 19) + 1;
	// Width of the bearing times gain product.
	localparam int PW  = AW + 25;
	// Width of the distance times gain sum.
	localparam int VW  = DW + 25;
	localparam logic signed [AW-1:0] ANG_HALF  = AW'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [AW-1:0] ANG_TENTH = AW'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
	localparam logic signed [ZW:0]   Z_ROUND   = (ZW + 1)'(64'sd1 <<< (29 - FRAC_BITS));

	// Configuration registers.
	logic [23:0]        lin_gain_q;
	logic [23:0]        ang_gain_q;
	logic [30:0]        max_lin_q;
	logic [30:0]        max_ang_q;
	logic [30:0]        stop_dist_q;
	logic signed [18:0] head_off_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q  <= 24'd65536;
			ang_gain_q  <= 24'd65536;
			max_lin_q   <= 31'd65536;
			max_ang_q   <= 31'd65536;
			stop_dist_q <= 31'd32768;
			head_off_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINEAR_GAIN:  lin_gain_q  <= cfg_data[23:0];
				REG_ANGULAR_GAIN: ang_gain_q  <= cfg_data[23:0];
				REG_MAX_LINEAR:   max_lin_q   <= cfg_data;
				REG_MAX_ANGULAR:  max_ang_q   <= cfg_data;
				REG_STOP_DIST:    stop_dist_q <= cfg_data;
				REG_HEAD_OFFSET:  head_off_q  <= $signed(cfg_data[18:0]);
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is empty or being taken.
	logic en;
	logic vld_s4;
	assign en       = !vld_s4 || m_tready;
	assign s_tready = en;

	// CORDIC stage registers; index 0 holds the pre-rotated input.
	logic signed [XW-1:0] cx_s [0:CORDIC_STAGES];
	logic signed [XW-1:0] cy_s [0:CORDIC_STAGES];
	logic signed [ZW-1:0] cz_s [0:CORDIC_STAGES];
	logic                 zero_s [0:CORDIC_STAGES];
	logic                 vld_c_s [0:CORDIC_STAGES];

	// Pre-rotation into the right half plane, and origin detection.
	logic signed [XW-1:0] in_x;
	logic signed [XW-1:0] in_y;
	assign in_x = XW'($signed(s_tdata[31:0]));
	assign in_y = XW'($signed(s_tdata[63:32]));

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			if (!in_x[XW-1]) begin
				cx_s[0] <= in_x;
				cy_s[0] <= in_y;
				cz_s[0] <= '0;
			end else if (!in_y[XW-1]) begin
				cx_s[0] <= in_y;
				cy_s[0] <= -in_x;
				cz_s[0] <= HALF_PI_Q30;
			end else begin
				cx_s[0] <= -in_y;
				cy_s[0] <= in_x;
				cz_s[0] <= -HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c_s[0] <= 1'b0;
		end else if (en) begin
			vld_c_s[0] <= s_tvalid;
		end
	end

	// One CORDIC vectoring iteration per stage, driving y toward zero.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] ATAN_I = atan_q30(i);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!cy_s[i][XW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ATAN_I;
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ATAN_I;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_c_s[i+1] <= vld_c_s[i];
			end
		end
	end

	// Stage 1: gain correction partial products and the rounded, offset bearing.
	logic [XW-2:0]        xf;
	logic signed [ZW:0]   z_rnd;
	logic signed [ARW-1:0] ang_rnd;
	assign xf      = cx_s[CORDIC_STAGES][XW-2:0];
	assign z_rnd   = (ZW + 1)'(cz_s[CORDIC_STAGES]) + Z_ROUND;
	assign ang_rnd = z_rnd[ZW:30-FRAC_BITS];

	logic [47:0]          dlo_s1;
	logic [46:0]          dhi_s1;
	logic signed [AW-1:0] ang_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dlo_s1 <= 48'(xf[17:0]) * 48'(KINV_Q30);
			dhi_s1 <= 47'(xf[34:18]) * 47'(KINV_Q30);
			if (zero_s[CORDIC_STAGES]) begin
				ang_s1 <= -AW'(head_off_q);
			end else begin
				ang_s1 <= AW'(ang_rnd) - AW'(head_off_q);
			end
		end
	end

	// Stage 2: distance, bearing times gain, and bearing window flags.
	logic [65:0]          dsum;
	assign dsum = (66'(dhi_s1) << 18) + 66'(dlo_s1) + (66'(1) << 29);

	logic [DW-1:0]        dist_s2;
	logic signed [PW-1:0] aprod_s2;
	logic                 big_s2;
	logic                 small_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s2  <= dsum[30+DW-1:30];
			aprod_s2 <= PW'(ang_s1) * PW'($signed({1'b0, ang_gain_q}));
			big_s2   <= (ang_s1 > ANG_HALF) || (ang_s1 < -ANG_HALF);
			small_s2 <= (ang_s1 < ANG_TENTH) && (ang_s1 > -ANG_TENTH);
		end
	end

	// Stage 3: turn speed rounding and clamp, forward speed partial products.
	logic signed [PW-1:0] va_sh;
	logic signed [PW-1:0] va_lim;
	assign va_sh  = (aprod_s2 + PW'(ANG_HALF)) >>> FRAC_BITS;
	assign va_lim = PW'($signed({1'b0, max_ang_q}));

	logic [41:0]        vlo_s3;
	logic [40:0]        vhi_s3;
	logic signed [31:0] va_s3;
	logic               stop_s3;
	logic               small_s3;
	logic               vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			vlo_s3   <= 42'(dist_s2[17:0]) * 42'(lin_gain_q);
			vhi_s3   <= 41'(dist_s2[34:18]) * 41'(lin_gain_q);
			stop_s3  <= (dist_s2 < DW'(stop_dist_q)) || big_s2;
			small_s3 <= small_s2;
			if (va_sh > va_lim) begin
				va_s3 <= va_lim[31:0];
			end else if (va_sh < -va_lim) begin
				va_s3 <= -va_lim[31:0];
			end else begin
				va_s3 <= va_sh[31:0];
			end
		end
	end

	// Stage 4: forward speed rounding, cap and deadbands into the output register.
	logic [VW-1:0] vsum;
	logic [VW-1:0] vl_sh;
	assign vsum  = (VW'(vhi_s3) << 18) + VW'(vlo_s3) + VW'(ANG_HALF);
	assign vl_sh = vsum >> FRAC_BITS;

	logic [30:0]        fwd_s4;
	logic signed [31:0] turn_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (stop_s3) begin
				fwd_s4 <= '0;
			end else if (vl_sh > VW'(max_lin_q)) begin
				fwd_s4 <= max_lin_q;
			end else begin
				fwd_s4 <= vl_sh[30:0];
			end
			turn_s4 <= small_s3 ? '0 : va_s3;
		end
	end

	// Valid bits of the post-CORDIC stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_c_s[CORDIC_STAGES];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {1'b0, turn_s4, fwd_s4};

endmodule

`default_nettype wire
